/* sv/btt_pkg.sv */
// Shared types, constants and score helpers for the bucketed transposition table.
package btt_pkg;

  localparam int WAYS        = 4;
  localparam int BUCKET_BITS = 12;
  localparam int BUCKETS     = 1 << BUCKET_BITS;
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KEY_W       = 64;
  localparam int SCORE_W     = 16;
  localparam int MT_W        = 15;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic signed [SCORE_W-1:0] SCORE_INF     = 16'sd32000;
  localparam logic signed [SCORE_W-1:0] SCORE_NEG_INF = -16'sd32000;
  localparam logic signed [17:0]        HALF_INF      = 18'sd16000;
  localparam logic [7:0]                NO_DEPTH      = 8'd255;
  localparam logic [7:0]                MAX_DEPTH     = 8'd254;
  localparam logic [7:0]                LAST_GEN      = 8'd255;
  localparam logic [MT_W-1:0]           MATE_RESET    = 15'd29976;

  typedef enum logic [1:0] {
    CMD_PROBE   = 2'd0,
    CMD_STORE   = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOK,
    ST_APPLY,
    ST_EMIT,
    ST_CLEAR
  } back_state_t;

  typedef struct packed {
    logic [7:0]                 lo_depth;
    logic [7:0]                 hi_depth;
    logic [7:0]                 gen;
    logic signed [SCORE_W-1:0]  lo_score;
    logic signed [SCORE_W-1:0]  hi_score;
    logic [15:0]                lo_move;
  } slot_value_t;

  localparam int VAL_W = $bits(slot_value_t);

  typedef struct packed {
    cmd_t                       cmd;
    logic [KEY_W-1:0]           key;
    logic                       key_zero;
    logic [7:0]                 depth;
    logic [7:0]                 ply;
    logic signed [SCORE_W-1:0]  window_lower;
    logic signed [SCORE_W-1:0]  window_upper;
    logic signed [SCORE_W-1:0]  bound_lower;
    logic signed [SCORE_W-1:0]  bound_upper;
    logic [15:0]                move_hint;
    logic                       depth_exact;
  } req_t;

  typedef struct packed {
    logic                       cutoff;
    logic                       scores_valid;
    logic                       key_found;
    logic [15:0]                best_move;
    logic signed [SCORE_W-1:0]  new_window_lower;
    logic signed [SCORE_W-1:0]  new_window_upper;
    logic signed [SCORE_W-1:0]  stored_lower;
    logic signed [SCORE_W-1:0]  stored_upper;
  } res_t;

  typedef struct packed {
    logic init_clr;
    logic loading;
    logic emitting;
  } back_status_t;

  // Empty slot value of a given generation
  function automatic slot_value_t empty_value(input logic [7:0] g);
    slot_value_t v;
    v.lo_depth = NO_DEPTH;
    v.hi_depth = NO_DEPTH;
    v.gen      = g;
    v.lo_score = '0;
    v.hi_score = '0;
    v.lo_move  = '0;
    return v;
  endfunction

  // Replacement depth plus one, zero when the slot holds no bound
  function automatic logic [8:0] repl_depth(input slot_value_t v);
    logic [8:0] a;
    logic [8:0] b;
    a = (v.lo_depth == NO_DEPTH) ? 9'd0 : ({1'b0, v.lo_depth} + 9'd1);
    b = (v.hi_depth == NO_DEPTH) ? 9'd0 : ({1'b0, v.hi_depth} + 9'd1);
    return (a > b) ? a : b;
  endfunction

  function automatic logic depth_ok(input logic [7:0] d, input logic [7:0] req,
                                    input logic exact);
    logic r;
    if (d == NO_DEPTH) r = 1'b0;
    else if (exact) r = (d == req);
    else r = (d >= req);
    return r;
  endfunction

  // Pull mate scores towards the root by ply
  function automatic logic signed [SCORE_W-1:0] adjust_score(
      input logic signed [SCORE_W-1:0] s, input logic [7:0] ply,
      input logic [MT_W-1:0] mt);
    logic signed [17:0] w;
    logic signed [17:0] m;
    logic signed [17:0] p;
    logic signed [17:0] r;
    w = 18'(s);
    m = $signed({3'b000, mt});
    p = $signed({10'd0, ply});
    if (w >= HALF_INF || w <= -HALF_INF) r = w;
    else if (w >= m) r = w - p;
    else if (w <= -m) r = w + p;
    else r = w;
    return r[SCORE_W-1:0];
  endfunction

  function automatic logic is_mate(input logic signed [SCORE_W-1:0] s,
                                   input logic [MT_W-1:0] mt);
    logic signed [17:0] w;
    logic signed [17:0] a;
    w = 18'(s);
    a = (w < 0) ? -w : w;
    return (s != SCORE_INF) && (s != SCORE_NEG_INF) && (a >= $signed({3'b000, mt}));
  endfunction

endpackage

/* sv/btt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module btt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/btt_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
module btt_front
  import btt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic [KEY_W-1:0]          key,
  input  logic [7:0]                depth,
  input  logic [7:0]                ply,
  input  logic signed [SCORE_W-1:0] window_lower,
  input  logic signed [SCORE_W-1:0] window_upper,
  input  logic signed [SCORE_W-1:0] bound_lower,
  input  logic signed [SCORE_W-1:0] bound_upper,
  input  logic [15:0]               move_hint,
  input  logic                      depth_exact,
  input  logic                      hold,
  output logic                      q_valid,
  output req_t                      q_req,
  input  logic                      q_pop
);

  req_t               entry;
  req_t               fifo [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;

  // Classify the incoming request: saturate a store depth, flag a zero key
  always_comb begin
    entry.cmd          = cmd_t'(cmd);
    entry.key          = key;
    entry.key_zero     = (key == '0);
    entry.depth        = (cmd_t'(cmd) == CMD_STORE && depth > MAX_DEPTH) ? MAX_DEPTH : depth;
    entry.ply          = ply;
    entry.window_lower = window_lower;
    entry.window_upper = window_upper;
    entry.bound_lower  = bound_lower;
    entry.bound_upper  = bound_upper;
    entry.move_hint    = move_hint;
    entry.depth_exact  = depth_exact;
  end

  assign in_ready = (count < Q_CNT_W'(Q_DEPTH)) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_req    = fifo[rd_ptr];

  // Store queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= entry;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end

endmodule

/* sv/btt_back.sv */
// Back end: bucket lookup, slot replacement, probe evaluation and table clearing.
module btt_back
  import btt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [MT_W-1:0] mate_threshold,
  input  logic            q_valid,
  input  req_t            q_req,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output res_t            out_res,
  output back_status_t    status
);

  back_state_t            state;
  back_state_t            state_next;
  req_t                   req;
  logic [7:0]             gen;
  logic [BUCKET_BITS-1:0] clr_cnt;
  logic                   init_clr;
  logic [WAY_BITS-1:0]    sel;
  logic                   found;
  logic                   do_write;
  logic                   fresh;
  logic                   set_key;
  logic                   lm;
  logic                   um;
  logic signed [SCORE_W-1:0] slo;
  logic signed [SCORE_W-1:0] shi;
  logic [15:0]            best;

  logic [WAYS*KEY_W-1:0]  krow;
  logic [WAYS*VAL_W-1:0]  vrow;
  logic [WAYS*KEY_W-1:0]  krow_w;
  logic [WAYS*VAL_W-1:0]  vrow_w;
  logic [KEY_W-1:0]       kslot [WAYS];
  slot_value_t            vslot [WAYS];

  logic                   ram_re;
  logic                   key_we;
  logic                   val_we;
  logic [BUCKET_BITS-1:0] key_waddr;
  logic                   load;
  res_t                   res;

  logic [WAY_BITS-1:0]    sel_next;
  logic                   found_next;
  logic                   do_write_next;
  logic                   fresh_next;
  logic                   set_key_next;
  slot_value_t            sel_val;
  slot_value_t            new_val;

  btt_ram #(.WIDTH(WAYS*KEY_W), .DEPTH(BUCKETS)) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (krow_w),
    .re    (ram_re),
    .raddr (req.key[BUCKET_BITS-1:0]),
    .rdata (krow)
  );

  btt_ram #(.WIDTH(WAYS*VAL_W), .DEPTH(BUCKETS)) u_vals (
    .clk   (clk),
    .we    (val_we),
    .waddr (req.key[BUCKET_BITS-1:0]),
    .wdata (vrow_w),
    .re    (ram_re),
    .raddr (req.key[BUCKET_BITS-1:0]),
    .rdata (vrow)
  );

  // Split the bucket row into slots
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      kslot[i] = krow[i*KEY_W +: KEY_W];
      vslot[i] = slot_value_t'(vrow[i*VAL_W +: VAL_W]);
    end
  end

  // Pick the slot a request works on
  always_comb begin
    logic       hit_any;
    logic       have_stale;
    logic [WAY_BITS-1:0] first;
    logic [WAY_BITS-1:0] stale;
    logic [WAY_BITS-1:0] shallow;
    hit_any    = 1'b0;
    have_stale = 1'b0;
    first      = '0;
    stale      = '0;
    shallow    = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (kslot[i] == '0 || kslot[i] == req.key) begin
        hit_any = 1'b1;
        first   = WAY_BITS'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (vslot[i].gen != gen) begin
        if (!have_stale || repl_depth(vslot[i]) < repl_depth(vslot[stale])) begin
          stale = WAY_BITS'(i);
        end
        have_stale = 1'b1;
      end else if (repl_depth(vslot[i]) < repl_depth(vslot[shallow])) begin
        shallow = WAY_BITS'(i);
      end
    end
    found_next = hit_any && (kslot[first] != '0);
    if (hit_any) begin
      sel_next      = first;
      do_write_next = 1'b1;
      set_key_next  = (kslot[first] == '0);
      fresh_next    = (kslot[first] == '0) || (vslot[first].gen != gen);
    end else if (have_stale) begin
      sel_next      = stale;
      do_write_next = 1'b1;
      set_key_next  = 1'b1;
      fresh_next    = 1'b1;
    end else begin
      sel_next      = shallow;
      do_write_next = ({1'b0, req.depth} + 9'd1) >= repl_depth(vslot[shallow]);
      set_key_next  = 1'b1;
      fresh_next    = 1'b1;
    end
  end

  // Merge the stored bounds into the chosen slot
  always_comb begin
    sel_val = vslot[sel];
    new_val = fresh ? empty_value(gen) : sel_val;
    if (req.bound_lower != SCORE_NEG_INF &&
        (new_val.lo_depth == NO_DEPTH || req.depth >= new_val.lo_depth)) begin
      new_val.lo_depth = req.depth;
      new_val.lo_score = req.bound_lower;
      new_val.lo_move  = req.move_hint;
    end
    if (req.bound_upper != SCORE_INF &&
        (new_val.hi_depth == NO_DEPTH || req.depth >= new_val.hi_depth)) begin
      new_val.hi_depth = req.depth;
      new_val.hi_score = req.bound_upper;
    end
    for (int i = 0; i < WAYS; i++) begin
      krow_w[i*KEY_W +: KEY_W] = (WAY_BITS'(i) == sel && set_key) ? req.key : kslot[i];
      vrow_w[i*VAL_W +: VAL_W] = (WAY_BITS'(i) == sel) ? new_val : vslot[i];
    end
    if (state == ST_CLEAR) begin
      krow_w = '0;
    end
  end

  // Form the result of a probe, zero for other commands
  always_comb begin
    logic avail;
    res   = '0;
    avail = (lm || um) && !is_mate(slo, mate_threshold) && !is_mate(shi, mate_threshold);
    if (req.cmd == CMD_PROBE) begin
      res.key_found        = found;
      res.best_move        = best;
      res.stored_lower     = slo;
      res.stored_upper     = shi;
      res.scores_valid     = avail;
      res.new_window_lower = req.window_lower;
      res.new_window_upper = req.window_upper;
      if (avail) begin
        if (slo != SCORE_NEG_INF && slo > req.window_lower) res.new_window_lower = slo;
        if (shi != SCORE_INF && shi < req.window_upper) res.new_window_upper = shi;
        res.cutoff = (slo == shi) ||
                     (slo != SCORE_NEG_INF && slo >= req.window_upper) ||
                     (shi != SCORE_INF && shi <= req.window_lower);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_req.cmd)
            CMD_PROBE:   state_next = ST_READ;
            CMD_STORE:   state_next = q_req.key_zero ? ST_EMIT : ST_READ;
            CMD_ADVANCE: state_next = (gen == LAST_GEN) ? ST_CLEAR : ST_EMIT;
            CMD_CLEAR:   state_next = ST_CLEAR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_APPLY;
      ST_APPLY: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_cnt == '1) state_next = init_clr ? ST_IDLE : ST_EMIT;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    key_we    = 1'b0;
    val_we    = 1'b0;
    load      = 1'b0;
    key_waddr = req.key[BUCKET_BITS-1:0];
    case (state)
      ST_IDLE:  q_pop  = q_valid;
      ST_READ:  ram_re = 1'b1;
      ST_APPLY: begin
        key_we = (req.cmd == CMD_STORE) && do_write;
        val_we = (req.cmd == CMD_STORE) && do_write;
      end
      ST_EMIT:  load = !out_valid || out_ready;
      ST_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_cnt;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init_clr  <= 1'b1;
      clr_cnt   <= '0;
      gen       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == '1) init_clr <= 1'b0;
      end
      if (q_pop) begin
        case (q_req.cmd)
          CMD_ADVANCE: gen <= (gen == LAST_GEN) ? 8'd1 : gen + 8'd1;
          CMD_CLEAR:   gen <= '0;
          default:     ;
        endcase
      end
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      req <= q_req;
    end
    if (state == ST_LOOK) begin
      sel      <= sel_next;
      found    <= found_next;
      do_write <= do_write_next;
      fresh    <= fresh_next;
      set_key  <= set_key_next;
    end
    if (state == ST_IDLE) begin
      lm   <= 1'b0;
      um   <= 1'b0;
      slo  <= SCORE_NEG_INF;
      shi  <= SCORE_INF;
      best <= '0;
    end else if (state == ST_APPLY && found) begin
      best <= sel_val.lo_move;
      if (sel_val.gen == gen) begin
        lm <= depth_ok(sel_val.lo_depth, req.depth, req.depth_exact);
        um <= depth_ok(sel_val.hi_depth, req.depth, req.depth_exact);
        if (depth_ok(sel_val.lo_depth, req.depth, req.depth_exact)) begin
          slo <= adjust_score(sel_val.lo_score, req.ply, mate_threshold);
        end
        if (depth_ok(sel_val.hi_depth, req.depth, req.depth_exact)) begin
          shi <= adjust_score(sel_val.hi_score, req.ply, mate_threshold);
        end
      end
    end
    if (load) begin
      out_res <= res;
    end
  end

  assign status.init_clr = init_clr;
  assign status.loading  = load;
  assign status.emitting = (state == ST_EMIT);

endmodule

/* sv/bucketed_transposition_table_unit.sv */
// Top level of the bucketed transposition table: ports, mate threshold register, checks.
//
//  channel   | handshake            | direction | payload
//  ----------+----------------------+-----------+---------------------------------------
//  request   | in_valid / in_ready  | in        | cmd key depth ply windows bounds move
//  result    | out_valid / out_ready| out       | cutoff flags best_move windows scores
//  config    | cfg_we               | in        | cfg_wdata (mate threshold)
//
// Probe and store pass through queue pop, bucket read, way select, slot update or
// score adjust and the result register; a store with a zero key and an advance
// without a wrap go from queue pop straight to the result register. A clear (and a
// generation wrap) sweeps all 4096 buckets of the key memory one bucket a cycle.
// After reset the same sweep runs with in_ready low. A two-entry queue lets requests
// arrive while the back end works, and a finished result holds while out_ready is low.
module bucketed_transposition_table_unit
  import btt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [MT_W-1:0]           cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic [KEY_W-1:0]          key,
  input  logic [7:0]                depth,
  input  logic [7:0]                ply,
  input  logic signed [SCORE_W-1:0] window_lower,
  input  logic signed [SCORE_W-1:0] window_upper,
  input  logic signed [SCORE_W-1:0] bound_lower,
  input  logic signed [SCORE_W-1:0] bound_upper,
  input  logic [15:0]               move_hint,
  input  logic                      depth_exact,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      cutoff,
  output logic                      scores_valid,
  output logic                      key_found,
  output logic [15:0]               best_move,
  output logic signed [SCORE_W-1:0] new_window_lower,
  output logic signed [SCORE_W-1:0] new_window_upper,
  output logic signed [SCORE_W-1:0] stored_lower,
  output logic signed [SCORE_W-1:0] stored_upper
);

  logic [MT_W-1:0] mate_threshold;
  logic            q_valid;
  req_t            q_req;
  logic            q_pop;
  res_t            res;
  back_status_t    back_st;

  // Hold the mate threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      mate_threshold <= MATE_RESET;
    end else if (cfg_we) begin
      mate_threshold <= cfg_wdata;
    end
  end

  btt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .key          (key),
    .depth        (depth),
    .ply          (ply),
    .window_lower (window_lower),
    .window_upper (window_upper),
    .bound_lower  (bound_lower),
    .bound_upper  (bound_upper),
    .move_hint    (move_hint),
    .depth_exact  (depth_exact),
    .hold         (back_st.init_clr),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_pop        (q_pop)
  );

  btt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .mate_threshold (mate_threshold),
    .q_valid        (q_valid),
    .q_req          (q_req),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res        (res),
    .status         (back_st)
  );

  assign cutoff           = res.cutoff;
  assign scores_valid     = res.scores_valid;
  assign key_found        = res.key_found;
  assign best_move        = res.best_move;
  assign new_window_lower = res.new_window_lower;
  assign new_window_upper = res.new_window_upper;
  assign stored_lower     = res.stored_lower;
  assign stored_upper     = res.stored_upper;

  // No request is taken while the post-reset sweep runs
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    back_st.init_clr |-> !in_ready)
    else $error("request accepted during reset sweep");

  // A taken result with nothing new loaded leaves the output empty
  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !back_st.loading) |=> !out_valid)
    else $error("result repeated");

  // A result only appears after the back end emitted it
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(back_st.emitting))
    else $error("result appeared without emit");

endmodule
